/* hw/rtl/rgbled_pkg.sv */
// Package for the RGB LED serial encoder.
// Holds widths, register indexes, reset values and the pulse length helper.
// No dependencies.
`default_nettype none

package rgbled_pkg;

    localparam int unsigned BITS_PER_WORD_DEF = 24;
    localparam int unsigned COLOR_W           = 24;
    localparam int unsigned TICK_W            = 8;
    localparam int unsigned CFG_ADDR_W        = 3;
    localparam int unsigned S_TDATA_W         = 24;
    localparam int unsigned M_TDATA_W         = 8;

    typedef logic [TICK_W-1:0]     tick_t;
    typedef logic [CFG_ADDR_W-1:0] cfg_addr_t;

    // Configuration register indexes.
    localparam cfg_addr_t REG_ONE_HIGH        = 3'd0;
    localparam cfg_addr_t REG_ZERO_HIGH       = 3'd1;
    localparam cfg_addr_t REG_ONE_LOW         = 3'd2;
    localparam cfg_addr_t REG_ZERO_LOW        = 3'd3;
    localparam cfg_addr_t REG_FINAL_ONE_LOW   = 3'd4;
    localparam cfg_addr_t REG_FINAL_ZERO_LOW  = 3'd5;

    // Reset values of the configuration registers.
    localparam tick_t RST_ONE_HIGH       = 8'd5;
    localparam tick_t RST_ZERO_HIGH      = 8'd1;
    localparam tick_t RST_ONE_LOW        = 8'd5;
    localparam tick_t RST_ZERO_LOW       = 8'd5;
    localparam tick_t RST_FINAL_ONE_LOW  = 8'd4;
    localparam tick_t RST_FINAL_ZERO_LOW = 8'd2;

    // Input command codes.
    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_LOAD = 1'b1;

    // A programmed length of zero behaves as a length of one.
    function automatic tick_t at_least_one(input tick_t v);
        at_least_one = (v == '0) ? tick_t'(1) : v;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/rgb_led_serial_encoder.sv */
// Top level of the RGB LED serial encoder: holding register, shift register,
// pulse timer and output register. Depends on rgbled_pkg.
//
// Usage:
//   The s_ channel carries commands. s_tuser selects a tick (0) or a load (1);
//   a load places s_tdata (the color word) and s_tlast (end of frame) in a
//   one-word holding register, and a tick advances the waveform by one unit.
//   Each accepted transfer produces exactly one m_ transfer with the pin level
//   for that tick, the holding register status, the sending flag, the load
//   rejection flag and, on m_tlast, the end of a frame.
//   The result of a transfer is in the output register on the next cycle.
//   One transfer is taken every cycle while the receiver is ready; the
//   throughput is set by the single output register, which is refilled in
//   the same cycle it is emptied.
//   When the receiver stalls, s_tready drops and the state holds, so no tick
//   is lost. Reset clears the line state (pin low, idle, holding register
//   empty), the output valid flag and restores the default pulse lengths.
//   Pulse lengths are written on the cfg_ port; the user must do so while
//   the encoder is idle (unenforced); writes past the last index are ignored.
`default_nettype none

module rgb_led_serial_encoder #(
    parameter int unsigned BITS_PER_WORD = rgbled_pkg::BITS_PER_WORD_DEF
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    // Input channel.
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [rgbled_pkg::S_TDATA_W-1:0]   s_tdata,  // [23:0] color_word
    input  wire logic                               s_tuser,  // [0] command
    input  wire logic                               s_tlast,  // last_word
    // Result channel.
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // [0] pin_level, [1] holding_empty, [2] sending, [3] load_rejected, rest 0
    output logic [rgbled_pkg::M_TDATA_W-1:0]        m_tdata,
    output logic                                    m_tlast,  // frame_done
    // Configuration port.
    input  wire logic                               cfg_wr_en,
    input  wire logic [rgbled_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  wire logic [rgbled_pkg::TICK_W-1:0]      cfg_wdata
);
    import rgbled_pkg::*;

    localparam int unsigned WORD_W = BITS_PER_WORD;
    localparam int unsigned POS_W  = $clog2(BITS_PER_WORD);
    localparam int unsigned EXT_W  = 32;
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(BITS_PER_WORD - 1);

    // Configuration registers.
    tick_t one_high_reg, zero_high_reg, one_low_reg, zero_low_reg;
    tick_t final_one_low_reg, final_zero_low_reg;

    // Line state.
    logic [WORD_W-1:0] shift_reg, shift_next;
    logic [WORD_W-1:0] held_word_reg, held_word_next;
    logic              held_full_reg, held_full_next;
    logic              held_last_reg, held_last_next;
    logic              cur_last_reg, cur_last_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    tick_t             timer_reg, timer_next;
    logic              high_reg, high_next;
    logic              busy_reg, busy_next;

    // Output register.
    logic              m_valid_reg;
    logic              pin_reg, pin_next;
    logic              empty_reg, empty_next;
    logic              sending_reg, sending_next;
    logic              done_reg, done_next;
    logic              rej_reg, rej_next;

    logic              s_accept;
    logic              start;
    logic [WORD_W-1:0] e_shift;
    logic [POS_W-1:0]  e_pos;
    logic              e_high;
    logic              e_last;
    tick_t             e_timer;
    tick_t             t_dec;
    logic              cur_bit;
    logic              final_bit;
    logic [EXT_W-1:0]  color_ext;

    assign s_tready = !m_valid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;

    assign color_ext = {{(EXT_W - COLOR_W){1'b0}}, s_tdata[COLOR_W-1:0]};

    // Effective state for a tick: a waiting word starts on the same tick.
    assign start   = !busy_reg && held_full_reg;
    assign e_shift = start ? held_word_reg : shift_reg;
    assign e_pos   = start ? '0 : pos_reg;
    assign e_high  = start ? 1'b1 : high_reg;
    assign e_last  = start ? held_last_reg : cur_last_reg;
    assign cur_bit = e_shift[WORD_W-1];
    assign e_timer = start
        ? at_least_one(cur_bit ? one_high_reg : zero_high_reg) : timer_reg;
    assign t_dec     = (e_timer != '0) ? e_timer - tick_t'(1) : e_timer;
    assign final_bit = (e_pos >= LAST_POS);

    always_comb begin
        shift_next     = shift_reg;
        held_word_next = held_word_reg;
        held_full_next = held_full_reg;
        held_last_next = held_last_reg;
        cur_last_next  = cur_last_reg;
        pos_next       = pos_reg;
        timer_next     = timer_reg;
        high_next      = high_reg;
        busy_next      = busy_reg;
        pin_next       = 1'b0;
        sending_next   = 1'b0;
        done_next      = 1'b0;
        rej_next       = 1'b0;

        if (s_tuser == CMD_LOAD) begin
            if (held_full_reg) begin
                rej_next = 1'b1;
            end else begin
                held_word_next = color_ext[WORD_W-1:0];
                held_last_next = s_tlast;
                held_full_next = 1'b1;
            end
            pin_next     = busy_reg && high_reg;
            sending_next = busy_reg;
        end else if (busy_reg || held_full_reg) begin
            // The word bit being sent is always the MSB of the shift register.
            // The holding register only empties when its word starts.
            held_full_next = held_full_reg && !start;
            busy_next      = 1'b1;
            shift_next     = e_shift;
            pos_next       = e_pos;
            high_next      = e_high;
            cur_last_next  = e_last;
            timer_next     = t_dec;
            sending_next   = 1'b1;
            pin_next       = e_high;
            if (t_dec == '0) begin
                if (e_high) begin
                    high_next  = 1'b0;
                    timer_next = final_bit
                        ? at_least_one(cur_bit ? final_one_low_reg : final_zero_low_reg)
                        : at_least_one(cur_bit ? one_low_reg : zero_low_reg);
                end else if (final_bit) begin
                    busy_next     = 1'b0;
                    pos_next      = '0;
                    done_next     = e_last;
                    cur_last_next = 1'b0;
                end else begin
                    pos_next   = e_pos + POS_W'(1);
                    high_next  = 1'b1;
                    shift_next = {e_shift[WORD_W-2:0], 1'b0};
                    timer_next = at_least_one(e_shift[WORD_W-2] ? one_high_reg
                                                                : zero_high_reg);
                end
            end
        end
        empty_next = !held_full_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shift_reg     <= '0;
            held_word_reg <= '0;
            held_full_reg <= 1'b0;
            held_last_reg <= 1'b0;
            cur_last_reg  <= 1'b0;
            pos_reg       <= '0;
            timer_reg     <= '0;
            high_reg      <= 1'b0;
            busy_reg      <= 1'b0;
        end else if (s_accept) begin
            shift_reg     <= shift_next;
            held_word_reg <= held_word_next;
            held_full_reg <= held_full_next;
            held_last_reg <= held_last_next;
            cur_last_reg  <= cur_last_next;
            pos_reg       <= pos_next;
            timer_reg     <= timer_next;
            high_reg      <= high_next;
            busy_reg      <= busy_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            pin_reg     <= pin_next;
            empty_reg   <= empty_next;
            sending_reg <= sending_next;
            done_reg    <= done_next;
            rej_reg     <= rej_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            one_high_reg       <= RST_ONE_HIGH;
            zero_high_reg      <= RST_ZERO_HIGH;
            one_low_reg        <= RST_ONE_LOW;
            zero_low_reg       <= RST_ZERO_LOW;
            final_one_low_reg  <= RST_FINAL_ONE_LOW;
            final_zero_low_reg <= RST_FINAL_ZERO_LOW;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_ONE_HIGH:       one_high_reg       <= cfg_wdata;
                REG_ZERO_HIGH:      zero_high_reg      <= cfg_wdata;
                REG_ONE_LOW:        one_low_reg        <= cfg_wdata;
                REG_ZERO_LOW:       zero_low_reg       <= cfg_wdata;
                REG_FINAL_ONE_LOW:  final_one_low_reg  <= cfg_wdata;
                REG_FINAL_ZERO_LOW: final_zero_low_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - 4){1'b0}}, rej_reg, sending_reg, empty_reg, pin_reg};
    assign m_tlast  = done_reg;

`ifndef NO_ASSERTIONS
    // A load that finds the holding register full is reported as rejected.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && s_tuser == CMD_LOAD && held_full_reg) |=> (m_tvalid && m_tdata[3]))
        else $error("full holding register load not flagged");

    // The end of a frame is only reported on a tick that belongs to a word.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> (m_tdata[2] && !m_tdata[3]))
        else $error("frame_done outside a word");

    // The line stays low whenever no word is being sent.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tdata[2]) |-> !m_tdata[0])
        else $error("pin high while idle");

    // The bit position never runs past the last bit of a word.
    assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= LAST_POS)
        else $error("bit position out of range");

    // While a word is in progress its phase timer is never left at zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (timer_reg != '0))
        else $error("phase timer empty during a word");
`endif

endmodule

`default_nettype wire
